/* src/sc1a_pkg.sv */
`default_nettype none

package sc1a_pkg;

    localparam int unsigned KEY_ROWS = 96;
    localparam logic [7:0] KEY_ROWS_LIMIT = 8'(KEY_ROWS);

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] K_CTRL = 7'h1D;
    localparam logic [6:0] K_SHIFT_L = 7'h2A;
    localparam logic [6:0] K_SHIFT_R = 7'h36;
    localparam logic [6:0] K_ALT = 7'h38;
    localparam logic [6:0] K_SPACE = 7'h39;
    localparam logic [6:0] K_CAPS = 7'h3A;
    localparam logic [6:0] K_NUM = 7'h45;
    localparam logic [6:0] K_SCROLL = 7'h46;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;

    typedef struct packed {
        logic [6:0] shifted;
        logic [6:0] plain;
    } rom_entry_t;

    function automatic rom_entry_t char_rom(input logic [6:0] code);
        rom_entry_t e;
        e = '{shifted: 7'h00, plain: 7'h00};
        unique case (code)
            7'h01: e = '{shifted: 7'h1B, plain: 7'h1B};
            7'h02: e = '{shifted: 7'h21, plain: 7'h31};
            7'h03: e = '{shifted: 7'h40, plain: 7'h32};
            7'h04: e = '{shifted: 7'h23, plain: 7'h33};
            7'h05: e = '{shifted: 7'h24, plain: 7'h34};
            7'h06: e = '{shifted: 7'h25, plain: 7'h35};
            7'h07: e = '{shifted: 7'h5E, plain: 7'h36};
            7'h08: e = '{shifted: 7'h26, plain: 7'h37};
            7'h09: e = '{shifted: 7'h2A, plain: 7'h38};
            7'h0A: e = '{shifted: 7'h28, plain: 7'h39};
            7'h0B: e = '{shifted: 7'h29, plain: 7'h30};
            7'h0C: e = '{shifted: 7'h5F, plain: 7'h2D};
            7'h0D: e = '{shifted: 7'h2B, plain: 7'h3D};
            7'h0E: e = '{shifted: 7'h08, plain: 7'h08};
            7'h0F: e = '{shifted: 7'h09, plain: 7'h09};
            7'h10: e = '{shifted: 7'h51, plain: 7'h71};
            7'h11: e = '{shifted: 7'h57, plain: 7'h77};
            7'h12: e = '{shifted: 7'h45, plain: 7'h65};
            7'h13: e = '{shifted: 7'h52, plain: 7'h72};
            7'h14: e = '{shifted: 7'h54, plain: 7'h74};
            7'h15: e = '{shifted: 7'h59, plain: 7'h79};
            7'h16: e = '{shifted: 7'h55, plain: 7'h75};
            7'h17: e = '{shifted: 7'h49, plain: 7'h69};
            7'h18: e = '{shifted: 7'h4F, plain: 7'h6F};
            7'h19: e = '{shifted: 7'h50, plain: 7'h70};
            7'h1A: e = '{shifted: 7'h7B, plain: 7'h5B};
            7'h1B: e = '{shifted: 7'h7D, plain: 7'h5D};
            7'h1C: e = '{shifted: 7'h0A, plain: 7'h0A};
            7'h1E: e = '{shifted: 7'h41, plain: 7'h61};
            7'h1F: e = '{shifted: 7'h53, plain: 7'h73};
            7'h20: e = '{shifted: 7'h44, plain: 7'h64};
            7'h21: e = '{shifted: 7'h46, plain: 7'h66};
            7'h22: e = '{shifted: 7'h47, plain: 7'h67};
            7'h23: e = '{shifted: 7'h48, plain: 7'h68};
            7'h24: e = '{shifted: 7'h4A, plain: 7'h6A};
            7'h25: e = '{shifted: 7'h4B, plain: 7'h6B};
            7'h26: e = '{shifted: 7'h4C, plain: 7'h6C};
            7'h27: e = '{shifted: 7'h3A, plain: 7'h3B};
            7'h28: e = '{shifted: 7'h22, plain: 7'h27};
            7'h29: e = '{shifted: 7'h7E, plain: 7'h60};
            7'h2B: e = '{shifted: 7'h7C, plain: 7'h5C};
            7'h2C: e = '{shifted: 7'h5A, plain: 7'h7A};
            7'h2D: e = '{shifted: 7'h58, plain: 7'h78};
            7'h2E: e = '{shifted: 7'h43, plain: 7'h63};
            7'h2F: e = '{shifted: 7'h56, plain: 7'h76};
            7'h30: e = '{shifted: 7'h42, plain: 7'h62};
            7'h31: e = '{shifted: 7'h4E, plain: 7'h6E};
            7'h32: e = '{shifted: 7'h4D, plain: 7'h6D};
            7'h33: e = '{shifted: 7'h3C, plain: 7'h2C};
            7'h34: e = '{shifted: 7'h3E, plain: 7'h2E};
            7'h35: e = '{shifted: 7'h3F, plain: 7'h2F};
            7'h37: e = '{shifted: 7'h2A, plain: 7'h2A};
            7'h39: e = '{shifted: 7'h20, plain: 7'h20};
            7'h47: e = '{shifted: 7'h00, plain: 7'h37};
            7'h48: e = '{shifted: 7'h00, plain: 7'h38};
            7'h49: e = '{shifted: 7'h00, plain: 7'h39};
            7'h4A: e = '{shifted: 7'h2D, plain: 7'h2D};
            7'h4B: e = '{shifted: 7'h00, plain: 7'h34};
            7'h4C: e = '{shifted: 7'h00, plain: 7'h35};
            7'h4D: e = '{shifted: 7'h00, plain: 7'h36};
            7'h4E: e = '{shifted: 7'h2B, plain: 7'h2B};
            7'h4F: e = '{shifted: 7'h00, plain: 7'h31};
            7'h50: e = '{shifted: 7'h00, plain: 7'h32};
            7'h51: e = '{shifted: 7'h00, plain: 7'h33};
            7'h52: e = '{shifted: 7'h00, plain: 7'h30};
            7'h53: e = '{shifted: 7'h7F, plain: 7'h2E};
            default: e = '{shifted: 7'h00, plain: 7'h00};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* src/scancode_set1_to_ascii_decoder_top.sv */
`default_nettype none

// Set-1 scancode to ASCII decoder. Each byte on the s_ side gives exactly one result on the
// m_ side, in order. A byte is captured in an input register; table lookup and flag update
// move it into the result register, so one byte per cycle is sustained while m_tready stays
// high. Byte 0xE0 arms the extended prefix for the next byte; codes at and above KEY_ROWS are
// ignored (the prefix is still consumed). The lock keys toggle on every press and raise
// leds_update. Only the modifier keys (shifts, ctrl, alt) are tracked as held, since no other
// held key changes any result.
module scancode_set1_to_ascii_decoder_top
    import sc1a_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // scan_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // char_valid[0], char_code[7:1], leds_update[8], led_bits[11:9],
    // shift_active[12], ctrl_active[13], alt_active[14], zero[15]
    output logic [15:0]      m_tdata
);

    typedef struct packed {
        logic prefix;
        logic caps;
        logic num;
        logic scroll;
        logic shift_l;
        logic shift_r;
        logic ctrl_n;
        logic ctrl_e;
        logic alt_n;
        logic alt_e;
    } kbd_state_t;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg, in_data_next;
    logic        out_valid_reg, out_valid_next;
    logic [14:0] out_data_reg, out_data_next;
    kbd_state_t  state_reg, state_next;

    logic        out_ready;
    logic        advance;
    logic [7:0]  b;
    logic [6:0]  code;
    logic        is_prefix;
    logic        in_range;
    logic        ext;
    logic        key_hit;
    logic        press;
    logic        lock_hit;
    logic        shift_sel;
    logic        is_lower;
    rom_entry_t  entry;
    logic [6:0]  ch;
    logic        ch_valid;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};

    always_comb begin
        b         = in_data_reg;
        code      = b[6:0];
        is_prefix = (b == PREFIX_BYTE);
        in_range  = ({1'b0, code} < KEY_ROWS_LIMIT);
        ext       = state_reg.prefix;
        key_hit   = !is_prefix && in_range;
        press     = key_hit && !b[7];
        lock_hit  = press && (code == K_CAPS || code == K_NUM || code == K_SCROLL);

        state_next        = state_reg;
        state_next.prefix = is_prefix;
        if (key_hit) begin
            if (ext) begin
                if (code == K_CTRL) state_next.ctrl_e = !b[7];
                if (code == K_ALT) state_next.alt_e = !b[7];
            end else begin
                if (code == K_SHIFT_L) state_next.shift_l = !b[7];
                if (code == K_SHIFT_R) state_next.shift_r = !b[7];
                if (code == K_CTRL) state_next.ctrl_n = !b[7];
                if (code == K_ALT) state_next.alt_n = !b[7];
            end
        end
        if (press && code == K_CAPS) state_next.caps = !state_reg.caps;
        if (press && code == K_NUM) state_next.num = !state_reg.num;
        if (press && code == K_SCROLL) state_next.scroll = !state_reg.scroll;

        // caps flips case for letters only, held shift flips every key
        entry     = char_rom(code);
        is_lower  = (entry.plain >= ASCII_LOWER_A) && (entry.plain <= ASCII_LOWER_Z);
        shift_sel = (state_next.caps && is_lower)
                  ^ (state_next.shift_l || state_next.shift_r);
        if ((ext && code == K_SPACE) || shift_sel) begin
            ch = entry.shifted;
        end else begin
            ch = entry.plain;
        end
        ch_valid = press && (ch != 7'h00);

        out_data_next = {
            state_next.alt_n || state_next.alt_e,
            state_next.ctrl_n || state_next.ctrl_e,
            state_next.shift_l || state_next.shift_r,
            state_next.caps, state_next.num, state_next.scroll,
            lock_hit,
            ch_valid ? ch : 7'h00,
            ch_valid
        };
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        if (advance) out_data_reg <= out_data_next;
    end

    // a produced character is never code zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[0]) |-> (out_data_reg[7:1] != 7'h00))
        else $error("char_valid with zero char_code");

    // a lock press always changes the led bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && lock_hit) |=>
            ({state_reg.caps, state_reg.num, state_reg.scroll}
             != $past({state_reg.caps, state_reg.num, state_reg.scroll})))
        else $error("lock press did not toggle led bits");

    // the prefix flag only rises on a prefix byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.prefix) |-> $past(advance && is_prefix))
        else $error("prefix flag set without prefix byte");

    // state only changes when an item moves to the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("keyboard state changed without an item");

endmodule

`default_nettype wire
